@@ design/brfr_pkg.sv @@
// Shared types, constants and helper functions of the bounded request FIFO.
package brfr_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int HANDLE_W = 16;
  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int CAP_W    = 7;
  localparam int OCC_W    = 7;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_e          status;
    entry_t           data;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

@@ design/brfr_chan_if.sv @@
// Valid/ready channel interfaces for requests, results and the capacity register.
interface brfr_req_if import brfr_pkg::*; ();
  logic                valid;
  logic                ready;
  op_e                 req_type;
  logic [HANDLE_W-1:0] handle;
  logic [SEC_W-1:0]    arrival_sec;
  logic [USEC_W-1:0]   arrival_usec;

  modport source (output valid, req_type, handle, arrival_sec, arrival_usec, input ready);
  modport sink   (input valid, req_type, handle, arrival_sec, arrival_usec, output ready);
endinterface

interface brfr_rsp_if import brfr_pkg::*; ();
  logic                valid;
  logic                ready;
  status_e             status;
  logic [HANDLE_W-1:0] handle_out;
  logic [SEC_W-1:0]    arrival_sec_out;
  logic [USEC_W-1:0]   arrival_usec_out;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, handle_out, arrival_sec_out, arrival_usec_out,
                  occupancy, input ready);
  modport sink   (input valid, status, handle_out, arrival_sec_out, arrival_usec_out,
                  occupancy, output ready);
endinterface

interface brfr_cfg_if import brfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] wdata;

  modport source (output valid, wdata, input ready);
  modport sink   (input valid, wdata, output ready);
endinterface

@@ design/brfr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module brfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/brfr_out.sv @@
// Output register that holds one finished result until the consumer takes it.
module brfr_out import brfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  result_t    res_i,
  output logic       res_ready_o,
  brfr_rsp_if.source rsp_o
);

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i && res_ready_o) begin
      valid_q <= 1'b1;
      data_q  <= res_i;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid            = valid_q;
  assign rsp_o.status           = data_q.status;
  assign rsp_o.handle_out       = data_q.data.handle;
  assign rsp_o.arrival_sec_out  = data_q.data.sec;
  assign rsp_o.arrival_usec_out = data_q.data.usec;
  assign rsp_o.occupancy        = data_q.occupancy;

endmodule

@@ design/brfr_ctrl.sv @@
// Sequencer that runs each request against the entry RAM and keeps the ring pointers.
module brfr_ctrl import brfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  brfr_req_if.sink req_i,
  brfr_cfg_if.sink cfg_i,
  output logic     res_valid_o,
  output result_t  res_o,
  input  logic     res_ready_i,
  output ram_req_t ram_req_o,
  input  entry_t   ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CMPT_RD,
    S_CMPT_WR,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    head_q;
  logic [IDX_W-1:0]    tail_q;
  logic [CNT_W-1:0]    count_q;
  logic [CAP_W-1:0]    capacity_q;
  op_e                 op_q;
  logic [HANDLE_W-1:0] key_q;
  logic [IDX_W-1:0]    ptr_q;
  logic [CNT_W-1:0]    walk_q;
  status_e             res_status_q;
  entry_t              res_data_q;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] limit;
  logic             full;
  logic             empty;
  logic             accept;
  logic [CNT_W-1:0] walk_inc;
  logic             more;

  // The limit saturates at the ring depth; zero capacity refuses every push.
  assign cap_ext  = CMP_W'(capacity_q);
  assign limit    = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign full     = CMP_W'(count_q) >= limit;
  assign empty    = count_q == '0;
  assign accept   = req_i.valid && req_i.ready;
  assign walk_inc = walk_q + CNT_W'(1);
  assign more     = walk_inc < count_q;

  assign req_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;

  assign res_valid_o      = state_q == S_RESP;
  assign res_o.status     = res_status_q;
  assign res_o.data       = res_data_q;
  assign res_o.occupancy  = OCC_W'(count_q);

  always_comb begin
    ram_req_o.we          = 1'b0;
    ram_req_o.waddr       = tail_q;
    ram_req_o.wdata.handle = req_i.handle;
    ram_req_o.wdata.sec   = req_i.arrival_sec;
    ram_req_o.wdata.usec  = req_i.arrival_usec;
    ram_req_o.re          = 1'b0;
    ram_req_o.raddr       = head_q;
    unique case (state_q)
      S_IDLE: begin
        ram_req_o.we = accept && (req_i.req_type == OP_PUSH) && !full;
        ram_req_o.re = accept;
      end
      S_SRCH_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ptr_q;
      end
      S_CMPT_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = slot_next(ptr_q);
      end
      S_CMPT_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ptr_q;
        ram_req_o.wdata = ram_rdata_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      capacity_q <= CAP_RESET;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        capacity_q <= cfg_i.wdata;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q         <= req_i.req_type;
            key_q        <= req_i.handle;
            ptr_q        <= head_q;
            walk_q       <= '0;
            res_status_q <= ST_OK;
            res_data_q   <= '0;
            unique case (req_i.req_type)
              OP_PUSH: begin
                if (full) begin
                  res_status_q <= ST_FULL;
                end else begin
                  tail_q  <= slot_next(tail_q);
                  count_q <= count_q + CNT_W'(1);
                end
                state_q <= S_RESP;
              end
              OP_POP, OP_PEEK: begin
                if (empty) begin
                  res_status_q <= ST_EMPTY;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_READ;
                end
              end
              OP_REMOVE: begin
                if (empty) begin
                  res_status_q <= ST_EMPTY;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_SRCH_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          res_data_q <= ram_rdata_i;
          if (op_q == OP_POP) begin
            head_q  <= slot_next(head_q);
            count_q <= count_q - CNT_W'(1);
          end
          state_q <= S_RESP;
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (ram_rdata_i.handle == key_q) begin
            // Match at ptr_q: shift the younger entries down, if there are any.
            if (more) begin
              walk_q  <= walk_inc;
              state_q <= S_CMPT_RD;
            end else begin
              tail_q  <= slot_prev(tail_q);
              count_q <= count_q - CNT_W'(1);
              state_q <= S_RESP;
            end
          end else if (more) begin
            walk_q  <= walk_inc;
            ptr_q   <= slot_next(ptr_q);
            state_q <= S_SRCH_RD;
          end else begin
            res_status_q <= ST_NOTFOUND;
            state_q      <= S_RESP;
          end
        end
        S_CMPT_RD: begin
          state_q <= S_CMPT_WR;
        end
        S_CMPT_WR: begin
          ptr_q  <= slot_next(ptr_q);
          walk_q <= walk_inc;
          if (more) begin
            state_q <= S_CMPT_RD;
          end else begin
            tail_q  <= slot_prev(tail_q);
            count_q <= count_q - CNT_W'(1);
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds ring depth");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q) == (CNT_W + 1)'(tail_q)) ||
    ((CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q) ==
     (CNT_W + 1)'(tail_q) + (CNT_W + 1)'(DEPTH)))
    else $error("head, tail and count disagree");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == OP_PUSH && !full) |=>
    count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted push did not add an entry");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD || state_q == S_CMPT_RD) |-> walk_q < count_q)
    else $error("search or compaction walked past the tail");
`endif

endmodule

@@ design/bounded_request_fifo_remove_by_key.sv @@
// Top level of the bounded request FIFO with remove by handle.
// A ring of DEPTH request entries (handle, arrival seconds, arrival
// microseconds) lives in one synchronous RAM with a registered read port,
// and a sequencer runs one request at a time against it while an output
// register holds the last result, so a new request is taken while a result
// still waits for its transfer. Each accepted request gives exactly one
// result carrying the status and the occupancy after the operation. Push and
// every empty request go from accept straight to the result hand-off; pop and
// peek pass through a read state for the head entry in between. Remove walks
// from the head with one RAM read and compare per entry, and on a match shifts
// each younger entry one slot toward the head with a read and a write. The
// entries searched plus the entries moved never exceed the occupancy, and the
// single RAM read port sets the pace of both walks.
// The capacity register is written through its own channel by the user only while
// the block is idle, which the block does not enforce; it saturates at DEPTH, and
// zero refuses every push. The entry RAM needs no clearing after reset, since no
// unoccupied entry reaches a result, so the block is ready as soon as reset ends.
module bounded_request_fifo_remove_by_key import brfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  brfr_req_if.sink   req_i,
  brfr_cfg_if.sink   cfg_i,
  brfr_rsp_if.source rsp_o
);

  result_t          res;
  logic             res_valid;
  logic             res_ready;
  ram_req_t         ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           ram_entry;

  assign ram_entry = entry_t'(ram_rdata);

  // Sequencer: pointers, occupancy, capacity and the remove walk.
  brfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_entry)
  );

  // Entry storage, one full entry per word.
  brfr_ram #(
    .Width (ENTRY_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Result register that decouples the sequencer from the consumer.
  brfr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .rsp_o       (rsp_o)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the bounded request FIFO with remove by handle.
module testbench;
  import brfr_pkg::*;

  // Clock period is 12 ns. The run is stopped hard after this many ns if the
  // block stops making progress.
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int TIMEOUT_NS     = 40_000_000;
  // The final quiet period covers the longest remove, a walk over all DEPTH
  // entries, with margin.
  localparam int END_CYCLES     = 300;
  // Every request gives a result, so once the last result has been taken
  // the sequencer is already idle; a short pause is enough before a write.
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst_n;

  brfr_req_if req_if ();
  brfr_rsp_if rsp_if ();
  brfr_cfg_if cfg_if ();

  bounded_request_fifo_remove_by_key dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the block: the held entries in arrival order (head first),
  // the capacity register, and the results still owed by the block.
  entry_t           fifo_image[$];
  logic [CAP_W-1:0] capacity_shadow;
  result_t          expected_results[$];

  // Odds of an idle burst per transfer on the request side and per cycle on
  // the result side; zero means no idling at all.
  int gap_odds;
  int stall_odds;

  int error_count;
  int reports_shown;
  int results_seen;
  int capacity_writes;
  int op_tally[4];
  int status_tally[4];

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Works out the result of one request and applies it to the shadow FIFO.
  // The data fields of the result are only filled for a successful pop or
  // peek; every other outcome reports zero there.
  function automatic result_t predict_fifo_result(input op_e op, input logic [HANDLE_W-1:0] key,
                                                  input logic [SEC_W-1:0] sec,
                                                  input logic [USEC_W-1:0] usec);
    result_t r;
    entry_t  fresh;
    int      limit;
    int      hit;
    r = '0;
    r.status = ST_OK;
    // Capacity values above DEPTH behave as DEPTH; zero refuses every push.
    limit = (capacity_shadow > DEPTH) ? DEPTH : int'(capacity_shadow);
    case (op)
      OP_PUSH: begin
        // Occupancy may sit above a freshly lowered capacity, hence >=.
        if (fifo_image.size() >= limit) begin
          r.status = ST_FULL;
        end else begin
          fresh.handle = key;
          fresh.sec    = sec;
          fresh.usec   = usec;
          fifo_image.push_back(fresh);
        end
      end
      OP_POP, OP_PEEK: begin
        if (fifo_image.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = fifo_image[0];
          if (op == OP_POP) fifo_image.pop_front();
        end
      end
      default: begin
        // Remove: the first match counted from the head goes, the others
        // keep their order. No match leaves the FIFO untouched.
        hit = -1;
        foreach (fifo_image[i]) begin
          if (hit < 0 && fifo_image[i].handle == key) hit = i;
        end
        if (fifo_image.size() == 0) r.status = ST_EMPTY;
        else if (hit < 0) r.status = ST_NOTFOUND;
        else fifo_image.delete(hit);
      end
    endcase
    r.occupancy = OCC_W'(fifo_image.size());
    return r;
  endfunction

  // Result side back-pressure: ready drops in bursts.
  // It only changes at the falling edge, once per cycle.
  initial begin : result_ready_driver
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_odds != 0 && ($urandom % stall_odds) == 0) begin
        stall_left = $urandom_range(5, 1) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= rst_n;
      end
    end
  end

  // Every result transfer is checked against the oldest owed result, field
  // by field. A result nobody asked for is a failure as well.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      status_tally[int'(rsp_if.status)]++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (reports_shown < MAX_REPORTS) begin
          reports_shown++;
          $display("[%0t] Unexpected result %0d: status %0d occupancy %0d", $realtime,
                   results_seen, rsp_if.status, rsp_if.occupancy);
        end
      end else begin
        want = expected_results.pop_front();
        if (want.status !== rsp_if.status || want.data.handle !== rsp_if.handle_out ||
            want.data.sec !== rsp_if.arrival_sec_out ||
            want.data.usec !== rsp_if.arrival_usec_out ||
            want.occupancy !== rsp_if.occupancy) begin
          error_count++;
          if (reports_shown < MAX_REPORTS) begin
            reports_shown++;
            $display("[%0t] Mismatch on result %0d:", $realtime, results_seen);
            $display("  expected status %0d handle %h sec %h usec %h occupancy %0d",
                     want.status, want.data.handle, want.data.sec, want.data.usec,
                     want.occupancy);
            $display("  actual   status %0d handle %h sec %h usec %h occupancy %0d",
                     rsp_if.status, rsp_if.handle_out, rsp_if.arrival_sec_out,
                     rsp_if.arrival_usec_out, rsp_if.occupancy);
          end
        end
      end
    end
  end

  // Sends one request. Valid is left high after the transfer so that the
  // next call can follow back to back; an idle burst or a drain lowers it.
  task automatic send_request(input op_e op, input logic [HANDLE_W-1:0] key,
                              input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec);
    int gap;
    @(negedge clk);
    if (gap_odds != 0 && ($urandom % gap_odds) == 0) begin
      gap = $urandom_range(5, 1);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= op;
    req_if.handle       <= key;
    req_if.arrival_sec  <= sec;
    req_if.arrival_usec <= usec;
    do @(posedge clk); while (!req_if.ready);
    // The transfer happens at this edge: predict right away so that the
    // shadow always matches what the block has taken in.
    expected_results.push_back(predict_fifo_result(op, key, sec, usec));
    op_tally[int'(op)]++;
  endtask

  // Lowers the request valid and waits until every owed result is back.
  task automatic wait_for_drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the capacity register; only called with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= value;
    do @(posedge clk); while (!cfg_if.ready);
    capacity_shadow = value;
    capacity_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic op_e pick_op(input int w_push, input int w_pop, input int w_remove,
                                  input int w_peek);
    int roll;
    roll = $urandom_range(w_push + w_pop + w_remove + w_peek - 1, 0);
    if (roll < w_push) return OP_PUSH;
    if (roll < w_push + w_pop) return OP_POP;
    if (roll < w_push + w_pop + w_remove) return OP_REMOVE;
    return OP_PEEK;
  endfunction

  // Random requests with the given operation weights. Pushed handles come
  // half from a small pool so that duplicates make "first match" matter.
  // Most removes look for a handle that is really held, the rest miss or
  // hit a duplicate by chance. Fields of pop and peek are random noise.
  task automatic run_random_mix(input int count, input int w_push, input int w_pop,
                                input int w_remove, input int w_peek);
    op_e                 op;
    logic [HANDLE_W-1:0] key;
    logic [SEC_W-1:0]    sec;
    logic [USEC_W-1:0]   usec;
    for (int n = 0; n < count; n++) begin
      op   = pick_op(w_push, w_pop, w_remove, w_peek);
      key  = ($urandom % 2 == 0) ? HANDLE_W'($urandom_range(15, 0)) : HANDLE_W'($urandom);
      sec  = $urandom;
      usec = ($urandom % 4 == 0) ? USEC_W'($urandom) : USEC_W'($urandom_range(999999, 0));
      if (op == OP_REMOVE && fifo_image.size() != 0 && $urandom_range(9, 0) < 7) begin
        key = fifo_image[$urandom_range(fifo_image.size() - 1, 0)].handle;
      end
      send_request(op, key, sec, usec);
    end
  endtask

  // Fills half the count, then drains the other half, so the occupancy
  // sweeps from low to high and back within one capacity setting.
  task automatic run_fill_drain(input int count);
    run_random_mix(count / 2, 6, 2, 1, 1);
    run_random_mix(count - count / 2, 2, 5, 2, 1);
  endtask

  // Pop, peek and remove right after reset all see an empty FIFO.
  task automatic test_empty_at_reset();
    send_request(OP_PEEK, 16'h0000, 32'h0, 20'h0);
    send_request(OP_POP, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_request(OP_REMOVE, 16'h0000, 32'h0, 20'h0);
  endtask

  // Extreme field values, including microseconds above 999999 which are
  // stored as given, and removes at the middle, a miss and the last entry.
  task automatic test_field_extremes();
    send_request(OP_PUSH, 16'h0000, 32'h0000_0000, 20'h0_0000);
    send_request(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_request(OP_PUSH, 16'h1234, 32'h0000_0005, 20'd999999);
    send_request(OP_PUSH, 16'hFFFF, 32'h8000_0001, 20'h5_5555);
    send_request(OP_PEEK, 16'hFFFF, 32'h0, 20'h0);
    // Two entries carry FFFF: only the older one may go.
    send_request(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_request(OP_REMOVE, 16'hABCD, 32'h0, 20'h0);
    send_request(OP_POP, 16'h0000, 32'h0, 20'h0);
    send_request(OP_POP, 16'h0000, 32'h0, 20'h0);
    send_request(OP_PEEK, 16'h0000, 32'h0, 20'h0);
    // Removing the only entry empties the FIFO.
    send_request(OP_REMOVE, 16'hFFFF, 32'h0, 20'h0);
    send_request(OP_POP, 16'h0000, 32'h0, 20'h0);
  endtask

  // Capacity zero, one, a saturating value and a value below the current
  // occupancy, which must refuse pushes but still allow draining.
  task automatic test_capacity_limits();
    write_capacity(CAP_W'(0));
    send_request(OP_PUSH, 16'h0042, 32'h1, 20'h1);
    send_request(OP_PEEK, 16'h0000, 32'h0, 20'h0);
    write_capacity(CAP_W'(1));
    send_request(OP_PUSH, 16'h0042, 32'h2, 20'h2);
    send_request(OP_PUSH, 16'h0043, 32'h3, 20'h3);
    send_request(OP_REMOVE, 16'h0042, 32'h0, 20'h0);
    write_capacity(CAP_W'(127));
    // Fill all DEPTH slots with random content; the extra push is refused.
    for (int n = 0; n <= DEPTH; n++) begin
      send_request(OP_PUSH, HANDLE_W'($urandom), $urandom, USEC_W'($urandom));
    end
    write_capacity(CAP_W'(10));
    send_request(OP_PUSH, 16'h7777, 32'h7, 20'h7);
    run_random_mix(150, 2, 5, 2, 1);
  endtask

  // Long random traffic across a range of capacities and idling patterns.
  // The last phase runs without any idling on either side.
  task automatic test_random_traffic();
    gap_odds = 4; stall_odds = 4;
    write_capacity(CAP_W'(64));
    run_fill_drain(300);
    gap_odds = 0; stall_odds = 3;
    write_capacity(CAP_W'(2));
    run_random_mix(150, 4, 3, 2, 1);
    gap_odds = 3; stall_odds = 0;
    write_capacity(CAP_W'(33));
    run_fill_drain(300);
    gap_odds = 2; stall_odds = 2;
    write_capacity(CAP_W'(100));
    run_fill_drain(300);
    gap_odds = 5; stall_odds = 5;
    write_capacity(CAP_W'($urandom_range(63, 3)));
    run_fill_drain(250);
    write_capacity(CAP_W'(1));
    run_random_mix(100, 4, 3, 2, 1);
    write_capacity(CAP_W'(0));
    run_random_mix(30, 4, 2, 2, 2);
    gap_odds = 0; stall_odds = 0;
    write_capacity(CAP_W'(64));
    run_fill_drain(200);
  endtask

  initial begin
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = OP_PUSH;
    req_if.handle       = '0;
    req_if.arrival_sec  = '0;
    req_if.arrival_usec = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.wdata        = '0;
    capacity_shadow     = CAP_RESET;
    gap_odds            = 4;
    stall_odds          = 4;
    error_count         = 0;
    reports_shown       = 0;
    results_seen        = 0;
    capacity_writes     = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_at_reset();
    test_field_extremes();
    test_capacity_limits();
    test_random_traffic();

    // All stimulus is in: collect the last results, then watch for strays.
    wait_for_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end

    $display("Covered %0d requests (%0d push, %0d pop, %0d remove, %0d peek)",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3], op_tally[0], op_tally[1],
             op_tally[2], op_tally[3]);
    $display("over %0d capacity writes. Results: %0d ok, %0d full, %0d empty, %0d not found.",
             capacity_writes, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #TIMEOUT_NS;
    $display("Run stopped by timeout with %0d results outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
design/brfr_pkg.sv
design/brfr_chan_if.sv
design/brfr_ram.sv
design/brfr_out.sv
design/brfr_ctrl.sv
design/bounded_request_fifo_remove_by_key.sv
dv/testbench.sv
